// File: rtl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Next-cycle implication, idle during reset.
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

// File: rtl/sfr_pkg.sv
// Package: types and constants of the serial frame receiver.
package sfr_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h03;
	localparam logic [7:0] SYNC_SECOND = 8'h9c;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_ID_HI = 3'd2,
		PH_ID_LO = 3'd3,
		PH_LEN   = 3'd4,
		PH_DATA  = 3'd5,
		PH_CHECK = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_MISMATCH = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [7:0]  byte_index;
		logic [15:0] frame_id;
		logic [7:0]  frame_length;
	} result_t;

endpackage

// File: rtl/sfr_if.sv
// Stream interfaces: received bytes in, frame results out.
interface sfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [7:0]  byte_index;
	logic [15:0] frame_id;
	logic [7:0]  frame_length;

	modport source (output valid, output kind, output payload_byte, output byte_index,
		output frame_id, output frame_length, input ready);
	modport sink (input valid, input kind, input payload_byte, input byte_index,
		input frame_id, input frame_length, output ready);
endinterface

// File: rtl/sfr_parser.sv
// Frame parser: phase machine, id/length capture, running checksum.
module sfr_parser import sfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [15:0] id_q, id_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  sum_add;
	logic [7:0]  count_inc;

	assign sum_add   = sum_q + rx_byte;
	assign count_inc = count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			id_q    <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (beat) begin
			phase_q <= phase_d;
			id_q    <= id_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		id_d      = id_q;
		len_d     = len_q;
		count_d   = count_q;
		sum_d     = sum_q;
		res_valid = 1'b0;
		res.kind         = KIND_PAYLOAD;
		res.payload_byte = '0;
		res.byte_index   = '0;
		res.frame_id     = id_q;
		res.frame_length = len_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == SYNC_FIRST) begin
					id_d    = '0;
					len_d   = '0;
					count_d = '0;
					sum_d   = rx_byte;
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					sum_d   = sum_add;
					phase_d = PH_ID_HI;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_ID_HI: begin
				id_d    = {rx_byte, 8'h00};
				sum_d   = sum_add;
				phase_d = PH_ID_LO;
			end
			PH_ID_LO: begin
				id_d    = {id_q[15:8], rx_byte};
				sum_d   = sum_add;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx_byte;
				sum_d   = sum_add;
				phase_d = (rx_byte == 8'h00) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				res_valid        = beat;
				res.payload_byte = rx_byte;
				res.byte_index   = count_q;
				sum_d            = sum_add;
				count_d          = count_inc;
				if (count_inc >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res_valid = beat;
				res.kind  = (sum_q == rx_byte) ? KIND_GOOD : KIND_MISMATCH;
				phase_d   = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

endmodule

// File: rtl/sfr_out_buf.sv
// Output register with one skid entry.
module sfr_out_buf import sfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  result_t      push_data,
	output logic         can_push,
	sfr_result_if.source result
);

	logic    out_valid_q, skid_valid_q;
	result_t out_data_q, skid_data_q;
	logic    take;

	assign take     = out_valid_q && result.ready;
	assign can_push = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.kind         = out_data_q.kind;
	assign result.payload_byte = out_data_q.payload_byte;
	assign result.byte_index   = out_data_q.byte_index;
	assign result.frame_id     = out_data_q.frame_id;
	assign result.frame_length = out_data_q.frame_length;

endmodule

// File: rtl/serial_frame_receiver_core.sv
// Latency: a result is on the output the cycle after its byte is taken, unless the output stalls.
// Throughput: one byte per cycle while the skid entry is free; the parser state updates once per accepted beat.
// A skid entry behind the output register keeps rx ready for one more beat while a
// result waits; rx stalls only when both output entries are full.
// Reset (arst_n low, asynchronous): parser hunts for the first sync byte, buffers empty.
module serial_frame_receiver_core import sfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sfr_byte_if.sink     rx,
	sfr_result_if.source result
);

	// A beat moves when the skid entry is free.
	logic    can_push;
	logic    beat;
	logic    res_valid;
	result_t res;

	assign rx.ready = can_push;
	assign beat     = rx.valid && can_push;

	// Sync hunt, header capture, payload count and additive checksum.
	sfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.rx_byte   (rx.rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	// Registered result with skid, decouples result.ready from rx.ready.
	sfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.can_push  (can_push),
		.result    (result)
	);

endmodule

// File: rtl/sfr_checker.sv
// Port checker for the serial frame receiver, bound to the top level.
`include "assert_macros.svh"

module sfr_checker import sfr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  payload_byte,
	input logic [7:0]  byte_index,
	input logic [15:0] frame_id,
	input logic [7:0]  frame_length
);

	`SFR_ASSERT_IMP(a_kind_legal, clk, arst_n, out_valid, kind == KIND_PAYLOAD || kind == KIND_GOOD || kind == KIND_MISMATCH)
	`SFR_ASSERT_IMP(a_status_zero, clk, arst_n, out_valid && kind != KIND_PAYLOAD, payload_byte == 8'h00 && byte_index == 8'h00)
	`SFR_ASSERT_IMP(a_index_in_len, clk, arst_n, out_valid && kind == KIND_PAYLOAD, byte_index < frame_length)
	`SFR_ASSERT_NXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(payload_byte) && $stable(frame_id))

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.kind         (result.kind),
	.payload_byte (result.payload_byte),
	.byte_index   (result.byte_index),
	.frame_id     (result.frame_id),
	.frame_length (result.frame_length)
);

// File: tb/tb_serial_frame_receiver_core.sv
// Self-checking testbench of serial_frame_receiver_core: directed table, random frames, predictor.
module tb_serial_frame_receiver_core import sfr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 8;
	// Count of random bytes outside the noise bursts; generation stops once this is reached.
	localparam int RANDOM_BYTES = 1900;
	// Drain time; a result passes through the output register and may wait in the skid entry.
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 2_000_000;

	// One beat of stimulus.
	// typed: the expected result is spelled out in want.
	// Otherwise the predictor supplies the expectation.
	typedef struct packed {
		logic [7:0] value;
		logic       typed;
		result_t    want;
	} rx_beat_t;

	// Directed part. Expected results are written out only where the answer is obvious.
	localparam rx_beat_t DIR_TABLE [25] = '{
		// Second sync byte while hunting: ignored.
		'{8'h9c, 1'b0, '0},
		// Broken sync: the second 0x03 is not taken as a new first sync byte,
		// so the 0x9c after it is ignored too.
		'{8'h03, 1'b0, '0},
		'{8'h03, 1'b0, '0},
		'{8'h9c, 1'b0, '0},
		// Zero length frame, all-ones id, correct check byte.
		'{8'h03, 1'b0, '0},
		'{8'h9c, 1'b0, '0},
		'{8'hff, 1'b0, '0},
		'{8'hff, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h9d, 1'b1, '{KIND_GOOD, 8'h00, 8'h00, 16'hffff, 8'h00}},
		// One payload byte, all-zero id, wrong check byte.
		'{8'h03, 1'b0, '0},
		'{8'h9c, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'hff, 1'b1, '{KIND_PAYLOAD, 8'hff, 8'h00, 16'h0000, 8'h01}},
		'{8'h00, 1'b1, '{KIND_MISMATCH, 8'h00, 8'h00, 16'h0000, 8'h01}},
		// Two payload bytes and a good check byte, through the predictor.
		'{8'h03, 1'b0, '0},
		'{8'h9c, 1'b0, '0},
		'{8'h12, 1'b0, '0},
		'{8'h34, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'h67, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	sfr_byte_if   rx_bus ();
	sfr_result_if res_bus ();

	serial_frame_receiver_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_bus),
		.result (res_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor copy of the parser state.
	phase_t      ph;
	logic [15:0] fid;
	logic [7:0]  flen;
	logic [7:0]  rcv_cnt;
	logic [7:0]  run_sum;

	rx_beat_t    stim_q [$];
	result_t     expect_q [$];

	rx_beat_t    cur_beat;
	result_t     pred_res;
	result_t     got_res;
	result_t     want_res;
	bit          stim_done;
	int unsigned rx_gap;
	int unsigned rx_calm;
	int unsigned res_stall;
	int unsigned res_calm;
	int unsigned errors;
	int unsigned cycle_cnt;

	// Advance the frame parser by one byte; returns 1 when the byte yields a result.
	function automatic bit frame_step(input logic [7:0] b, output result_t r);
		bit got;
		got = 1'b0;
		r = '0;
		case (ph)
			PH_HUNT: begin
				// Frame start clears the header fields and seeds the sum.
				if (b == SYNC_FIRST) begin
					fid = '0;
					flen = '0;
					rcv_cnt = '0;
					run_sum = b;
					ph = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (b == SYNC_SECOND) begin
					run_sum = run_sum + b;
					ph = PH_ID_HI;
				end else begin
					ph = PH_HUNT;
				end
			end
			PH_ID_HI: begin
				fid = {b, 8'h00};
				run_sum = run_sum + b;
				ph = PH_ID_LO;
			end
			PH_ID_LO: begin
				fid = {fid[15:8], b};
				run_sum = run_sum + b;
				ph = PH_LEN;
			end
			PH_LEN: begin
				flen = b;
				run_sum = run_sum + b;
				ph = (b == 8'h00) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				r = '{KIND_PAYLOAD, b, rcv_cnt, fid, flen};
				got = 1'b1;
				run_sum = run_sum + b;
				rcv_cnt = rcv_cnt + 8'd1;
				if (rcv_cnt >= flen) ph = PH_CHECK;
			end
			PH_CHECK: begin
				r = '{(run_sum == b) ? KIND_GOOD : KIND_MISMATCH, 8'h00, 8'h00, fid, flen};
				got = 1'b1;
				ph = PH_HUNT;
			end
			default: begin
				ph = PH_HUNT;
			end
		endcase
		return got;
	endfunction

	// Idle length for either side: mostly none, sometimes short, rarely long,
	// with occasional calm stretches of back-to-back beats.
	function automatic int unsigned idle_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 999);
		if (r < 5) begin
			calm = $urandom_range(50, 300);
			return 0;
		end
		if (r < 600) return 0;
		if (r < 900) return $urandom_range(1, 3);
		if (r < 985) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Append one predicted beat; the frame sum tracks every byte pushed.
	logic [7:0]  gen_sum;
	int unsigned gen_count;

	task automatic push_beat(input logic [7:0] v, input bit counted);
		stim_q.push_back('{v, 1'b0, '0});
		gen_sum = gen_sum + v;
		if (counted) gen_count++;
	endtask

	// Sender: hold the beat until taken, then idle or present the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_bus.valid && rx_bus.ready) begin
				if (frame_step(cur_beat.value, pred_res) && !cur_beat.typed)
					expect_q.push_back(pred_res);
				if (cur_beat.typed) expect_q.push_back(cur_beat.want);
			end
			if (rx_bus.valid && !rx_bus.ready) begin
				// beat not taken yet: keep valid and data as they are
			end else if (rx_gap > 0) begin
				rx_gap--;
				rx_bus.valid <= 1'b0;
			end else if (stim_q.size() > 0) begin
				cur_beat = stim_q.pop_front();
				rx_bus.valid <= 1'b1;
				rx_bus.rx_byte <= cur_beat.value;
				rx_gap = idle_gap(rx_calm);
			end else begin
				rx_bus.valid <= 1'b0;
				stim_done = 1'b1;
			end
		end
	end

	// Receiver: check every taken result against the oldest expectation,
	// then stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				got_res = '{res_bus.kind, res_bus.payload_byte, res_bus.byte_index,
					res_bus.frame_id, res_bus.frame_length};
				if (expect_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, %s%0d %h %0d %h %0d",
						$time, "got kind/pay/idx/id/len=",
						got_res.kind, got_res.payload_byte, got_res.byte_index,
						got_res.frame_id, got_res.frame_length);
					errors++;
				end else begin
					want_res = expect_q.pop_front();
					if (got_res !== want_res) begin
						$display("%0t: result mismatch: expected %0d %h %0d %h %0d, %s",
							$time, want_res.kind, want_res.payload_byte,
							want_res.byte_index, want_res.frame_id,
							want_res.frame_length, "got (kind pay idx id len)");
						$display("%0t:   got %0d %h %0d %h %0d",
							$time, got_res.kind, got_res.payload_byte,
							got_res.byte_index, got_res.frame_id, got_res.frame_length);
						errors++;
					end
				end
			end
			if (res_stall > 0) begin
				res_stall--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
				res_stall = idle_gap(res_calm);
			end
		end
	end

	// Watchdog.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("status: fail");
		$finish;
	end

	initial begin : main_seq
		int unsigned pick;
		int unsigned frame_cnt;
		int unsigned plen;
		logic [15:0] gid;
		logic [7:0]  v;

		clk = 1'b0;
		arst_n = 1'b0;
		rx_bus.valid = 1'b0;
		rx_bus.rx_byte = '0;
		res_bus.ready = 1'b0;
		ph = PH_HUNT;
		fid = '0;
		flen = '0;
		rcv_cnt = '0;
		run_sum = '0;
		stim_done = 1'b0;
		rx_gap = 0;
		rx_calm = 0;
		res_stall = 0;
		res_calm = 0;
		errors = 0;
		cur_beat = '0;
		gen_sum = '0;
		gen_count = 0;
		frame_cnt = 0;

		foreach (DIR_TABLE[i]) stim_q.push_back(DIR_TABLE[i]);

		// Random part: mostly well-formed frames with random content, some line noise
		// and some broken sync pairs.
		while (gen_count < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// noise while hunting: not counted, and ignored unless it holds the first sync byte
				repeat ($urandom_range(1, 4)) push_beat(8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 14) begin
				// first sync byte followed by anything but the second one
				push_beat(SYNC_FIRST, 1'b1);
				v = 8'($urandom_range(0, 255));
				if (v == SYNC_SECOND) v = v + 8'd1;
				push_beat(v, 1'b1);
			end else begin
				// full frame; the first one carries the longest payload
				pick = $urandom_range(0, 99);
				if (frame_cnt == 0) plen = 255;
				else if (pick < 2) plen = $urandom_range(128, 255);
				else if (pick < 15) plen = $urandom_range(7, 24);
				else plen = $urandom_range(0, 6);
				gid = 16'($urandom_range(0, 65535));
				gen_sum = '0;
				push_beat(SYNC_FIRST, 1'b1);
				push_beat(SYNC_SECOND, 1'b1);
				push_beat(gid[15:8], 1'b1);
				push_beat(gid[7:0], 1'b1);
				push_beat(plen[7:0], 1'b1);
				repeat (plen) push_beat(8'($urandom_range(0, 255)), 1'b1);
				// about one frame in four carries a corrupted check byte
				if ($urandom_range(0, 3) == 0) v = gen_sum ^ 8'($urandom_range(1, 255));
				else v = gen_sum;
				push_beat(v, 1'b1);
				frame_cnt++;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (!(stim_done && expect_q.size() == 0));
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expect_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expect_q.size());
			errors++;
		end
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/sfr_parser.sv
rtl/sfr_out_buf.sv
rtl/serial_frame_receiver_core.sv
rtl/sfr_checker.sv
tb/tb_serial_frame_receiver_core.sv
